>>> rtl/solution_separation_protection_level_assert.svh
// Assertion macros shared by the protection level block.
`ifndef SOLUTION_SEPARATION_PROTECTION_LEVEL_ASSERT_SVH
`define SOLUTION_SEPARATION_PROTECTION_LEVEL_ASSERT_SVH
// Implication checked at every clock edge, quiet during reset.
`define SSPL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SSPL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/sspl_pkg.sv
// Package: types, constants and helpers for the protection level block.
package sspl_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [31:0] GAIN_MAIN = 32'd349307;
  localparam logic [31:0] GAIN_SEP  = 32'd334234;
  localparam logic [31:0] U32MAX    = 32'hFFFF_FFFF;
  localparam logic [0:0] KIND_START  = 1'b0;
  localparam logic [0:0] KIND_SUBSET = 1'b1;
  localparam logic [1:0] MODE_SAT   = 2'd1;
  localparam logic [1:0] MODE_FIXED = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_EXCL   = 2'd1;
  localparam logic [1:0] ACT_FLOAT  = 2'd2;

  typedef struct packed {
    logic [0:0]  kind;
    logic        last;
    logic [31:0] sigma_east;
    logic [31:0] sigma_north;
    logic [31:0] sigma_up;
    logic signed [31:0] sep_east;
    logic signed [31:0] sep_north;
    logic signed [31:0] sep_up;
    logic [7:0]  subset_id;
    logic [1:0]  subset_mode;
    logic [7:0]  satellite;
    logic [31:0] ftest;
  } item_t;

  typedef struct packed {
    logic [31:0] hpl;
    logic [31:0] vpl;
    logic [7:0]  hor_src_id;
    logic [1:0]  hor_src_mode;
    logic [7:0]  hor_src_sat;
    logic [7:0]  ver_src_id;
    logic [7:0]  ver_src_sat;
    logic [1:0]  fde_mode;
    logic [7:0]  fde_id;
    logic [7:0]  fde_sat;
    logic [1:0]  fde_action;
    logic [31:0] fde_score;
  } result_t;

  // Round half up, shift out 16 gain fraction bits, saturate.
  function automatic logic [31:0] gain_round(input logic [63:0] p);
    logic [64:0] r;
    r = {1'b0, p} + 65'd32768;
    gain_round = (r[64:48] != 17'd0) ? U32MAX : r[47:16];
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[32] ? U32MAX : s[31:0];
  endfunction
endpackage

>>> rtl/sspl_queue.sv
// Short FIFO between the front end and the execution back end.
module sspl_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sspl_pkg::item_t    push_data,
  input  logic               pop,
  output logic               not_empty,
  output logic               full,
  output sspl_pkg::item_t    head
);
  sspl_pkg::item_t mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign head      = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> rtl/sspl_sqrt.sv
// Shared iterative unit: 64-bit integer square root or 64/32 division, one bit a cycle.
module sspl_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic        is_div,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [32:0] res
);
  logic [63:0] rem;
  logic [63:0] n;
  logic [32:0] q;
  logic [6:0]  cnt;
  logic        run, dv;
  logic [65:0] trial;
  logic [65:0] rem_sh;

  // Division runs 64 steps: restoring, remainder fits 33 bits.
  // Square root runs 32 steps on pairs of bits.
  always_comb begin
    if (dv) begin
      rem_sh = {1'b0, rem, n[63]};
      trial  = {34'd0, den};
    end else begin
      rem_sh = {rem, n[63:62]};
      trial  = {31'd0, q, 2'b01};
    end
  end

  assign done = run && (cnt == 7'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= 7'd0;
    end else if (go) begin
      run <= 1'b1;
      dv  <= is_div;
      cnt <= is_div ? 7'd64 : 7'd32;
      rem <= 64'd0;
      n   <= num;
      q   <= 33'd0;
    end else if (run) begin
      if (cnt == 7'd0) begin
        run <= 1'b0;
      end else begin
        cnt <= cnt - 7'd1;
        n   <= dv ? {n[62:0], 1'b0} : {n[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem <= 64'(rem_sh - trial);
          q   <= {q[32] | q[31], q[30:0], 1'b1};
        end else begin
          rem <= rem_sh[63:0];
          q   <= {q[32] | q[31], q[30:0], 1'b0};
        end
      end
    end
  end

  // Quotient can exceed 32 bits; track overflow as a sticky top bit.
  always_comb res = q;
endmodule

>>> rtl/sspl_exec.sv
// Back end: per-item arithmetic sequencer, state and result formation.
`include "solution_separation_protection_level_assert.svh"
module sspl_exec #(
  parameter int FRAC_BITS = sspl_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fde_enable,
  input  logic              have,
  input  sspl_pkg::item_t   it,
  output logic              pop,
  output logic              idle,
  output logic              result_valid,
  output sspl_pkg::result_t result
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_SQ   = 9'b000000100,
    S_EX   = 9'b000001000,
    S_TH   = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_NEXT = 9'b001000000,
    S_HPL  = 9'b010000000,
    S_OUT  = 9'b100000000
  } st_t;
  st_t st;

  logic [31:0] main_sigma [3];
  logic [31:0] axis_bound [3];
  logic [31:0] main_ftest;
  logic [17:0] hor_source, ver_source;
  logic [51:0] best_fault;
  sspl_pkg::item_t cur;
  logic [1:0]  ax;
  logic [1:0]  ph;
  logic [31:0] score, th, ex;
  logic [63:0] s2, m2, prod;
  logic        go, is_div, u_done;
  logic [63:0] u_num;
  logic [31:0] u_den;
  logic [32:0] u_res;
  logic [31:0] sig, mag;
  logic signed [31:0] sep;
  logic [31:0] cand, gm;
  logic [64:0] hsum;
  logic [1:0]  act;

  sspl_sqrt u_sqrt (
    .clk(clk), .rst(rst), .go(go), .is_div(is_div), .num(u_num), .den(u_den),
    .done(u_done), .res(u_res)
  );

  always_comb begin
    case (ax)
      2'd0: begin sig = cur.sigma_east;  sep = cur.sep_east;  end
      2'd1: begin sig = cur.sigma_north; sep = cur.sep_north; end
      default: begin sig = cur.sigma_up; sep = cur.sep_up; end
    endcase
    mag  = sep[31] ? 32'(-sep) : sep;
    gm   = sspl_pkg::gain_round(prod);
    cand = sspl_pkg::sat_add(gm, th);
    hsum = {1'b0, s2} + {1'b0, m2};
    case (cur.subset_mode)
      sspl_pkg::MODE_SAT:   act = sspl_pkg::ACT_EXCL;
      sspl_pkg::MODE_FIXED: act = sspl_pkg::ACT_FLOAT;
      default:              act = sspl_pkg::ACT_NONE;
    endcase
  end

  assign idle = (st == S_IDLE);
  assign pop  = (st == S_IDLE) && have;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      go <= 1'b0;
      ph <= 2'd0;
      result_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        main_sigma[i] <= 32'd0;
        axis_bound[i] <= 32'd0;
      end
      main_ftest <= 32'd0;
      hor_source <= 18'd0;
      ver_source <= 18'd0;
      best_fault <= 52'd0;
    end else begin
      go <= 1'b0;
      result_valid <= 1'b0;
      case (st)
        S_IDLE: if (have) begin
          cur <= it;
          ax  <= 2'd0;
          score <= 32'd0;
          st  <= S_MUL;
        end
        // Register the gain product and the two squares for this axis.
        S_MUL: begin
          prod <= 64'(sig) * 64'(sspl_pkg::GAIN_MAIN);
          s2   <= 64'(sig) * 64'(sig);
          m2   <= 64'(main_sigma[ax]) * 64'(main_sigma[ax]);
          st   <= S_SQ;
        end
        S_SQ: begin
          if (cur.kind == sspl_pkg::KIND_START) begin
            main_sigma[ax] <= sig;
            axis_bound[ax] <= gm;
            st <= S_NEXT;
          end else begin
            th <= 32'd0;
            if (s2 > m2) begin
              u_num <= s2 - m2;
              is_div <= 1'b0;
              go <= 1'b1;
              st <= S_EX;
            end else begin
              ex <= 32'd0;
              st <= S_TH;
            end
          end
        end
        S_EX: if (u_done) begin
          ex <= u_res[31:0];
          st <= S_TH;
        end
        S_TH: begin
          prod <= 64'(ex) * 64'(sspl_pkg::GAIN_SEP);
          ph   <= 2'd1;
          st   <= S_DIV;
          is_div <= 1'b1;
        end
        S_DIV: begin
          if (ph == 2'd1) begin
            // First cycle here: finish th, launch the division unless th is zero.
            ph <= 2'd0;
            th <= gm;
            u_num <= 64'(mag) << FRAC_BITS;
            u_den <= gm;
            if (gm != 32'd0) go <= 1'b1;
            else st <= S_NEXT;
          end else if (u_done) begin
            if (u_res[32] || u_res[31:0] > score)
              score <= u_res[32] ? 32'hFFFF_FFFF : u_res[31:0];
            st <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (cur.kind == sspl_pkg::KIND_SUBSET) begin
            prod <= 64'(sig) * 64'(sspl_pkg::GAIN_MAIN);
          end
          if (ax == 2'd2) begin
            if (cur.kind == sspl_pkg::KIND_START) begin
              main_ftest <= cur.ftest;
              hor_source <= 18'd0;
              ver_source <= 18'd0;
              best_fault <= 52'd0;
            end else if (score > best_fault[31:0]) begin
              best_fault <= {cur.subset_mode, cur.subset_id, cur.satellite, act, score};
            end
          end
          st <= S_HPL;
        end
        // Bound update for the finished axis of a subset beat, then next axis, idle or result.
        S_HPL: begin
          if (cur.kind == sspl_pkg::KIND_SUBSET && cand > axis_bound[ax]) begin
            axis_bound[ax] <= cand;
            if (ax == 2'd2)
              ver_source <= {cur.subset_id, cur.subset_mode, cur.satellite};
            else
              hor_source <= {cur.subset_id, cur.subset_mode, cur.satellite};
          end
          if (ax != 2'd2) begin
            ax <= ax + 2'd1;
            st <= S_MUL;
          end else if (!cur.last) begin
            st <= S_IDLE;
          end else begin
            st <= S_OUT;
          end
        end
        // Squares, then the HPL root (or saturate), then drive the result.
        S_OUT: begin
          if (ph == 2'd0) begin
            s2 <= 64'(axis_bound[0]) * 64'(axis_bound[0]);
            m2 <= 64'(axis_bound[1]) * 64'(axis_bound[1]);
            is_div <= 1'b0;
            ph <= 2'd1;
          end else if (ph == 2'd1) begin
            if (hsum[64]) begin
              result.hpl <= 32'hFFFF_FFFF;
              ph <= 2'd3;
            end else begin
              u_num <= hsum[63:0];
              go <= 1'b1;
              ph <= 2'd2;
            end
          end else if (ph == 2'd2) begin
            if (u_done) begin
              result.hpl <= u_res[31:0];
              ph <= 2'd3;
            end
          end else begin
            result.vpl          <= axis_bound[2];
            result.hor_src_id   <= hor_source[17:10];
            result.hor_src_mode <= hor_source[9:8];
            result.hor_src_sat  <= hor_source[7:0];
            result.ver_src_id   <= ver_source[17:10];
            result.ver_src_sat  <= ver_source[7:0];
            if (!fde_enable || main_ftest <= (32'd4 << FRAC_BITS)
                || best_fault[31:0] <= (32'd1 << FRAC_BITS)) begin
              result.fde_mode <= 2'd0; result.fde_id <= 8'd0; result.fde_sat <= 8'd0;
              result.fde_action <= 2'd0; result.fde_score <= 32'd0;
            end else begin
              result.fde_mode   <= best_fault[51:50];
              result.fde_id     <= best_fault[49:42];
              result.fde_sat    <= best_fault[41:34];
              result.fde_action <= best_fault[33:32];
              result.fde_score  <= best_fault[31:0];
            end
            result_valid <= 1'b1;
            ph <= 2'd0;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `SSPL_ASSERT_NEXT(a_done_one, result_valid, !result_valid)
  `SSPL_ASSERT_IMP(a_pop_idle, pop, idle)
  `SSPL_ASSERT_IMP(a_ax_range, !idle, ax != 2'd3)
endmodule

>>> rtl/solution_separation_protection_level.sv
// Top level: solution-separation protection level with fault detection and exclusion.
// An epoch is a start beat (main sigmas and F-test), then subset beats; the beat
// with last set yields one result strobe, which the receiver must take at once.
// A subset beat may run, per axis, one square root and one 64-step division
// on a single shared bit-serial unit in the back end, skipped when the subset
// sigma does not exceed the main sigma. A last beat adds the HPL square root,
// skipped when the sum of squares saturates. A two-entry queue lets the host
// issue the next beat while the back end is still working; busy reflects a
// full queue. Write fde_enable only when the block is idle.
`include "solution_separation_protection_level_assert.svh"
module solution_separation_protection_level #(
  parameter int FRAC_BITS = sspl_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  sspl_pkg::item_t    item,
  input  logic               cfg_we,
  input  logic               cfg_data,
  output logic               done,
  output sspl_pkg::result_t  result
);
  logic fde_enable;
  logic q_ne, q_full, pop, idle;
  sspl_pkg::item_t head;

  always_ff @(posedge clk) begin
    if (rst) fde_enable <= 1'b0;
    else if (cfg_we) fde_enable <= cfg_data;
  end

  assign busy = q_full;

  sspl_queue u_q (
    .clk(clk), .rst(rst), .push(start && !busy), .push_data(item), .pop(pop),
    .not_empty(q_ne), .full(q_full), .head(head)
  );

  sspl_exec #(.FRAC_BITS(FRAC_BITS)) u_exec (
    .clk(clk), .rst(rst), .fde_enable(fde_enable), .have(q_ne), .it(head),
    .pop(pop), .idle(idle), .result_valid(done), .result(result)
  );

  `SSPL_ASSERT_IMP(a_no_pop_empty, pop, q_ne)
  `SSPL_ASSERT_IMP(a_done_idle, done, idle)
  `SSPL_ASSERT_NEXT(a_accept_nonempty, start && !busy, q_ne)
endmodule
